@@ src/cbor_item_skip_validator_top_assert.svh @@
// Assertion macros for the checker file of this block.
`ifndef CBOR_ITEM_SKIP_VALIDATOR_TOP_ASSERT_SVH
`define CBOR_ITEM_SKIP_VALIDATOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled while rst is high.
`define CISV_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while rst is high.
`define CISV_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/cisv_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package cisv_pkg;

   localparam int STACK_LEVELS = 16;
   localparam int DEPTH_W     = $clog2(STACK_LEVELS + 1);
   localparam int IDX_W       = (STACK_LEVELS > 1) ? $clog2(STACK_LEVELS) : 1;
   localparam int CFG_DEPTH_W = 5;
   localparam int CMP_W       = (DEPTH_W > CFG_DEPTH_W) ? DEPTH_W : CFG_DEPTH_W;
   localparam int ITEMS_W     = 32;
   localparam int ARG_W       = 64;
   localparam int CHILD_W     = 33;
   localparam int COUNT_W     = 32;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 32;
   localparam int REQ_DATA_W  = 8;
   localparam int RSP_DATA_W  = 40;

   localparam logic [CFG_DEPTH_W-1:0] RST_MAX_NESTING = 5'd16;
   localparam logic [ITEMS_W-1:0]     RST_MAX_ITEMS   = 32'd4096;

   // Additional-info codes: 24..27 announce a 1/2/4/8 byte argument, 28 and up are invalid.
   localparam logic [4:0] AI_ARG1     = 5'd24;
   localparam logic [4:0] AI_RESERVED = 5'd28;

   localparam logic [2:0] MJ_BYTES = 3'd2;
   localparam logic [2:0] MJ_TEXT  = 3'd3;
   localparam logic [2:0] MJ_ARRAY = 3'd4;
   localparam logic [2:0] MJ_MAP   = 3'd5;
   localparam logic [2:0] MJ_TAG   = 3'd6;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAX_NESTING = 1'b0,
      CSR_MAX_ITEMS   = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_BOUNDS  = 2'd1,
      ST_INVALID = 2'd2,
      ST_LIMIT   = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      PH_HEAD    = 4'b0001,
      PH_ARG     = 4'b0010,
      PH_PAYLOAD = 4'b0100,
      PH_DROP    = 4'b1000
   } phase_type;

   typedef enum logic [1:0] {
      STK_NONE  = 2'd0,
      STK_PUSH  = 2'd1,
      STK_POP   = 2'd2,
      STK_CLEAR = 2'd3
   } stack_op_type;

   typedef struct packed {
      stack_op_type       op;
      logic [CHILD_W-1:0] value;
   } stack_cmd_type;

   typedef struct packed {
      logic [DEPTH_W-1:0] depth;
      logic               pop_all;
   } stack_stat_type;

   typedef struct packed {
      phase_type          phase;
      logic [3:0]         arg_left;
      logic [ARG_W-1:0]   arg_value;
      logic [2:0]         cur_major;
      logic [ARG_W-1:0]   payload_left;
      logic [COUNT_W-1:0] byte_count;
      logic [2:0]         top_major;
   } parse_state_type;

   typedef struct packed {
      status_type         status;
      logic [2:0]         item_major;
      logic [COUNT_W-1:0] item_length;
   } result_type;

   localparam stack_cmd_type STACK_IDLE = '{op: STK_NONE, value: '0};

   localparam parse_state_type PARSE_IDLE = '{
      phase:        PH_HEAD,
      arg_left:     4'd0,
      arg_value:    '0,
      cur_major:    3'd0,
      payload_left: '0,
      byte_count:   '0,
      top_major:    3'd0
   };

endpackage
`default_nettype wire

@@ src/cisv_nest_stack.sv @@
`timescale 1ns / 1ps
`default_nettype none
module cisv_nest_stack
   import cisv_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  stack_cmd_type       cmd,
   output stack_stat_type      stat
);

   logic [DEPTH_W-1:0] depth_ff;
   logic [DEPTH_W-1:0] depth_in;
   logic [CHILD_W-1:0] stack_ff [STACK_LEVELS];
   logic               one_ff   [STACK_LEVELS];
   logic               found;
   logic [IDX_W-1:0]   keep_idx;

   // The deepest level whose count stays nonzero after a decrement is where a
   // finished child stops popping; every level above it holds exactly one.
   always_comb begin
      found    = 1'b0;
      keep_idx = '0;
      for (int i = 0; i < STACK_LEVELS; i++) begin
         if ((DEPTH_W'(i) < depth_ff) && !one_ff[i]) begin
            found    = 1'b1;
            keep_idx = IDX_W'(i);
         end
      end
   end

   always_comb begin
      case (cmd.op)
         STK_PUSH:  depth_in = depth_ff + DEPTH_W'(1);
         STK_POP:   depth_in = found ? (DEPTH_W'(keep_idx) + DEPTH_W'(1)) : '0;
         STK_CLEAR: depth_in = '0;
         default:   depth_in = depth_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
      end else begin
         depth_ff <= depth_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < STACK_LEVELS; i++) begin
         if ((cmd.op == STK_PUSH) && (depth_ff[IDX_W-1:0] == IDX_W'(i))) begin
            stack_ff[i] <= cmd.value;
            one_ff[i]   <= (cmd.value == CHILD_W'(1));
         end else if ((cmd.op == STK_POP) && found && (keep_idx == IDX_W'(i))) begin
            stack_ff[i] <= stack_ff[i] - CHILD_W'(1);
            one_ff[i]   <= (stack_ff[i] == CHILD_W'(2));
         end
      end
   end

   assign stat.depth   = depth_ff;
   assign stat.pop_all = !found;

endmodule
`default_nettype wire

@@ src/cisv_parser.sv @@
`timescale 1ns / 1ps
`default_nettype none
module cisv_parser
   import cisv_pkg::*;
(
   input  parse_state_type            cur,
   input  wire logic [REQ_DATA_W-1:0] data_byte,
   input  wire logic                  end_of_buffer,
   input  stack_stat_type             stk,
   input  wire logic [CFG_DEPTH_W-1:0] cfg_depth,
   input  wire logic [ITEMS_W-1:0]    cfg_items,
   output parse_state_type            nxt,
   output stack_cmd_type              cmd,
   output logic                       res_valid,
   output result_type                 res
);

   logic [4:0]         ai;
   logic [2:0]         major;
   logic [ARG_W-1:0]   val;
   logic               head_done;
   logic               child;
   logic               push;
   logic [CHILD_W-1:0] push_val;
   logic               more;
   status_type         code;
   logic [COUNT_W-1:0] cnt_base;
   logic [CMP_W-1:0]   depth_c;
   logic [CMP_W-1:0]   cfg_c;
   logic [CMP_W-1:0]   lim_c;
   logic               at_limit;
   logic               over_items;

   always_comb begin
      ai       = data_byte[4:0];
      depth_c  = CMP_W'(stk.depth);
      cfg_c    = CMP_W'(cfg_depth);
      lim_c    = (cfg_c < CMP_W'(STACK_LEVELS)) ? cfg_c : CMP_W'(STACK_LEVELS);
      at_limit = (depth_c >= lim_c);

      nxt       = cur;
      cmd.op    = STK_NONE;
      cmd.value = '0;
      res_valid = 1'b0;
      res       = '{status: ST_OK, item_major: cur.top_major, item_length: cur.byte_count};
      major     = cur.cur_major;
      val       = cur.arg_value;
      head_done = 1'b0;
      child     = 1'b0;
      push      = 1'b0;
      push_val  = '0;
      more      = 1'b1;
      code      = ST_OK;
      cnt_base  = '0;
      over_items = 1'b0;

      if (cur.phase == PH_DROP) begin
         if (end_of_buffer) begin
            nxt    = PARSE_IDLE;
            cmd.op = STK_CLEAR;
         end
      end else begin
         // A new top-level item restarts the byte count.
         cnt_base = ((cur.phase == PH_HEAD) && (stk.depth == '0)) ? '0 : cur.byte_count;
         nxt.byte_count = (cnt_base == {COUNT_W{1'b1}}) ? cnt_base
                                                        : cnt_base + COUNT_W'(1);

         case (cur.phase)
            PH_HEAD: begin
               major         = data_byte[7:5];
               nxt.cur_major = major;
               if (stk.depth == '0) begin
                  nxt.top_major = major;
               end
               if (ai >= AI_RESERVED) begin
                  more = 1'b0;
                  code = ST_INVALID;
               end else if (ai >= AI_ARG1) begin
                  // The low two bits of 24..27 select 1, 2, 4 or 8 argument bytes.
                  nxt.arg_left  = 4'(4'd1 << ai[1:0]);
                  nxt.arg_value = '0;
                  nxt.phase     = PH_ARG;
               end else begin
                  val       = ARG_W'(ai);
                  head_done = 1'b1;
               end
            end
            PH_ARG: begin
               val           = {cur.arg_value[ARG_W-9:0], data_byte};
               nxt.arg_value = val;
               nxt.arg_left  = cur.arg_left - 4'd1;
               if (cur.arg_left == 4'd1) begin
                  head_done = 1'b1;
               end
            end
            PH_PAYLOAD: begin
               nxt.payload_left = cur.payload_left - ARG_W'(1);
               if (cur.payload_left == ARG_W'(1)) begin
                  nxt.phase = PH_HEAD;
                  child     = 1'b1;
               end
            end
            default: begin
            end
         endcase

         over_items = (val[ARG_W-1:ITEMS_W] != '0) || (val[ITEMS_W-1:0] > cfg_items);

         if (head_done) begin
            nxt.phase = PH_HEAD;
            case (major)
               MJ_BYTES, MJ_TEXT: begin
                  if (val == '0) begin
                     child = 1'b1;
                  end else begin
                     nxt.payload_left = val;
                     nxt.phase        = PH_PAYLOAD;
                  end
               end
               MJ_ARRAY: begin
                  if (over_items) begin
                     more = 1'b0;
                     code = ST_LIMIT;
                  end else begin
                     push     = 1'b1;
                     push_val = val[CHILD_W-1:0];
                  end
               end
               MJ_MAP: begin
                  if (over_items) begin
                     more = 1'b0;
                     code = ST_LIMIT;
                  end else begin
                     push     = 1'b1;
                     push_val = {val[ITEMS_W-1:0], 1'b0};
                  end
               end
               MJ_TAG: begin
                  push     = 1'b1;
                  push_val = CHILD_W'(1);
               end
               default: child = 1'b1;
            endcase
         end

         // The depth limit applies to empty containers as well.
         if (push) begin
            if (at_limit) begin
               more = 1'b0;
               code = ST_LIMIT;
            end else if (push_val == '0) begin
               child = 1'b1;
            end else begin
               cmd.op    = STK_PUSH;
               cmd.value = push_val;
            end
         end

         if (child) begin
            cmd.op = STK_POP;
            if (stk.pop_all) begin
               more = 1'b0;
               code = ST_OK;
            end
         end

         res_valid = !more || end_of_buffer;
         res.status      = more ? ST_BOUNDS : code;
         res.item_major  = nxt.top_major;
         res.item_length = nxt.byte_count;

         if (res_valid) begin
            if ((res.status == ST_OK) || end_of_buffer) begin
               nxt    = PARSE_IDLE;
               cmd.op = STK_CLEAR;
            end else begin
               nxt.phase = PH_DROP;
               cmd.op    = STK_NONE;
            end
         end
      end
   end

endmodule
`default_nettype wire

@@ src/cbor_item_skip_validator_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Walks a buffer of definite-length CBOR items one byte per word on the req_ channel
// (tlast marks the last byte) and sends one rsp_ word when a top-level item completes
// (status ok) or when it fails: out of buffer at tlast, invalid encoding for additional
// info 28 to 31, or limit exceeded for an array or map count above the configured item
// limit or nesting at max_nesting_depth (at most 16). After an error, bytes are dropped
// up to and including the next tlast. A byte is taken every cycle unless rsp_tready
// stalls a result word; each byte is decoded between the input and result registers,
// and a finished child pops all exhausted nesting levels at once through a priority
// check over the 16 stack levels. No clearing pass follows reset. The user writes
// configuration through csr_ while no item is in flight; the block does not check.
module cbor_item_skip_validator_top
   import cisv_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_DATA_W-1:0]  req_tdata,   // [7:0] data_byte
   input  wire logic                   req_tlast,   // end_of_buffer
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]       rsp_tdata,   // [1:0] status, [4:2] item_major,
                                                    // [36:5] item_length, [39:37] zero
   input  wire logic                   csr_we,
   input  wire logic [CSR_IDX_W-1:0]   csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic                   in_valid_ff;
   logic                   in_valid_in;
   logic [REQ_DATA_W-1:0]  in_byte_ff;
   logic                   in_last_ff;
   parse_state_type        state_ff;
   parse_state_type        state_in;
   logic                   out_valid_ff;
   logic                   out_valid_in;
   result_type             out_data_ff;
   logic [CFG_DEPTH_W-1:0] cfg_depth_ff;
   logic [ITEMS_W-1:0]     cfg_items_ff;

   logic                   fire;
   logic                   req_take;
   logic                   res_valid;
   result_type             res;
   parse_state_type        parse_nxt;
   stack_cmd_type          parse_cmd;
   stack_cmd_type          stack_cmd;
   stack_stat_type         stack_stat;

   // The held byte moves on whenever the result register is free or being emptied.
   assign fire       = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || fire;
   assign req_take   = req_tvalid && req_tready;

   assign in_valid_in  = req_take || (in_valid_ff && !fire);
   assign out_valid_in = fire ? res_valid : (out_valid_ff && !rsp_tready);
   assign state_in     = fire ? parse_nxt : state_ff;
   assign stack_cmd    = fire ? parse_cmd : STACK_IDLE;

   cisv_parser u_parser (
      .cur           (state_ff),
      .data_byte     (in_byte_ff),
      .end_of_buffer (in_last_ff),
      .stk           (stack_stat),
      .cfg_depth     (cfg_depth_ff),
      .cfg_items     (cfg_items_ff),
      .nxt           (parse_nxt),
      .cmd           (parse_cmd),
      .res_valid     (res_valid),
      .res           (res)
   );

   cisv_nest_stack u_stack (
      .clock (clock),
      .reset (reset),
      .cmd   (stack_cmd),
      .stat  (stack_stat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= PARSE_IDLE;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (fire && res_valid) begin
         out_data_ff <= res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_depth_ff <= RST_MAX_NESTING;
         cfg_items_ff <= RST_MAX_ITEMS;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_MAX_NESTING: cfg_depth_ff <= csr_wdata[CFG_DEPTH_W-1:0];
            CSR_MAX_ITEMS:   cfg_items_ff <= csr_wdata[ITEMS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, out_data_ff.item_length, out_data_ff.item_major,
                        out_data_ff.status};

endmodule
`default_nettype wire

@@ src/cisv_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "cbor_item_skip_validator_top_assert.svh"
module cisv_checker
   import cisv_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tready,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata
);

   // A stalled result word keeps its contents.
   `CISV_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "rsp word changed while stalled")

   // With the result register empty nothing blocks the input side.
   `CISV_ASSERT_IMPL(a_ready_when_empty, clock, reset, !rsp_tvalid, req_tready, "req_tready low with no pending result")

   // Every result covers at least the byte that produced it.
   `CISV_ASSERT_IMPL(a_length_nonzero, clock, reset, rsp_tvalid, rsp_tdata[36:5] != 32'd0, "result with zero item length")

   // The first cycle out of reset shows no result.
   `CISV_ASSERT_IMPL(a_quiet_after_reset, clock, 1'b0, $past(reset) && !reset, !rsp_tvalid, "result valid right after reset")

endmodule

bind cbor_item_skip_validator_top cisv_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire
